/* src/ccw_pkg.sv */
// ----------------------------------------------------------------------------
// ccw_pkg - calendar clock shared definitions
// Beat layouts, field limits, month codes and the calendar helper functions.
// ----------------------------------------------------------------------------
package ccw_pkg;

	// action codes
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_SET  = 1'b1;

	// keep mask bit positions
	localparam int KEEP_YEAR   = 0;
	localparam int KEEP_MONTH  = 1;
	localparam int KEEP_DAY    = 2;
	localparam int KEEP_HOUR   = 3;
	localparam int KEEP_MINUTE = 4;
	localparam int KEEP_SECOND = 5;

	// roll-over limits
	localparam logic [5:0] SECOND_MAX  = 6'd59;
	localparam logic [5:0] MINUTE_MAX  = 6'd59;
	localparam logic [4:0] HOUR_MAX    = 5'd23;
	localparam logic [2:0] WEEKDAY_MAX = 3'd6;
	localparam logic [3:0] MONTH_MAX   = 4'd12;

	// months
	localparam logic [3:0] JAN = 4'd1;
	localparam logic [3:0] FEB = 4'd2;
	localparam logic [3:0] APR = 4'd4;
	localparam logic [3:0] JUN = 4'd6;
	localparam logic [3:0] SEP = 4'd9;
	localparam logic [3:0] NOV = 4'd11;
	localparam logic [3:0] DEC = 4'd12;

	// month lengths
	localparam logic [4:0] LEN_28 = 5'd28;
	localparam logic [4:0] LEN_29 = 5'd29;
	localparam logic [4:0] LEN_30 = 5'd30;
	localparam logic [4:0] LEN_31 = 5'd31;

	// reset values
	localparam logic [4:0] DAY_FIRST     = 5'd1;
	localparam logic [2:0] WEEKDAY_RESET = 3'd4;

	// year offset handling: offset 0 is 2015
	localparam logic [8:0] BASE_YY     = 9'd15;   // 2015 mod 100
	localparam logic [7:0] OFFSET_2100 = 8'd85;
	localparam logic [7:0] OFFSET_2200 = 8'd185;
	localparam logic [8:0] CENTURY     = 9'd100;
	localparam logic [8:0] TWO_CENTURY = 9'd200;
	// 6 - 2 * (century mod 4) for the 20th, 21st and 22nd hundreds
	localparam logic [2:0] CENT_20 = 3'd6;
	localparam logic [2:0] CENT_21 = 3'd4;
	localparam logic [2:0] CENT_22 = 3'd2;
	localparam logic [1:0] LEAP_PHASE = 2'd1;     // offset mod 4 of a leap year
	localparam logic [2:0] LEAP_JAN_CODE = 3'd6;
	localparam logic [2:0] LEAP_FEB_CODE = 3'd2;

	typedef struct packed {
		logic       action;
		logic [5:0] keep_mask;
		logic [7:0] new_year;
		logic [3:0] new_month;
		logic [4:0] new_day;
		logic [4:0] new_hour;
		logic [5:0] new_minute;
		logic [5:0] new_second;
	} item_t;

	typedef struct packed {
		logic [7:0] year_out;
		logic [3:0] month_out;
		logic [4:0] day_out;
		logic [4:0] hour_out;
		logic [5:0] minute_out;
		logic [5:0] second_out;
		logic [2:0] weekday_out;
	} result_t;

	// month table of the weekday formula, zero for a month out of range
	function automatic logic [2:0] month_code(input logic [3:0] month);
		logic [2:0] code;
		begin
			case (month)
				4'd1:    code = 3'd0;
				4'd2:    code = 3'd3;
				4'd3:    code = 3'd3;
				4'd4:    code = 3'd6;
				4'd5:    code = 3'd1;
				4'd6:    code = 3'd4;
				4'd7:    code = 3'd6;
				4'd8:    code = 3'd2;
				4'd9:    code = 3'd5;
				4'd10:   code = 3'd0;
				4'd11:   code = 3'd3;
				4'd12:   code = 3'd5;
				default: code = 3'd0;
			endcase
			return code;
		end
	endfunction

	// february follows the plain divide-by-four rule
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic [7:0] year);
		logic [4:0] len;
		begin
			if (month == FEB) begin
				len = (year[1:0] == LEAP_PHASE) ? LEN_29 : LEN_28;
			end else if (month inside {APR, JUN, SEP, NOV}) begin
				len = LEN_30;
			end else begin
				len = LEN_31;
			end
			return len;
		end
	endfunction

	// remainder by seven of an 8-bit value by folding (64 and 8 are 1 mod 7)
	function automatic logic [2:0] mod7(input logic [7:0] value);
		logic [6:0] fold_a;
		logic [3:0] fold_b;
		logic [3:0] rem;
		begin
			fold_a = 7'(value[5:0]) + 7'(value[7:6]);
			fold_b = 4'(fold_a[6:3]) + 4'(fold_a[2:0]);
			if (fold_b >= 4'd14) begin
				rem = fold_b - 4'd14;
			end else if (fold_b >= 4'd7) begin
				rem = fold_b - 4'd7;
			end else begin
				rem = fold_b;
			end
			return rem[2:0];
		end
	endfunction

	// weekday from the table formula, gregorian leap test
	function automatic logic [2:0] weekday_of(input logic [7:0] year, input logic [3:0] month,
		input logic [4:0] day);
		logic [8:0] yoff;
		logic [6:0] yy;
		logic [2:0] cent;
		logic       leap;
		logic [2:0] code;
		logic [7:0] sum;
		begin
			yoff = 9'(year) + BASE_YY;
			if (year < OFFSET_2100) begin
				yy   = 7'(yoff);
				cent = CENT_20;
			end else if (year < OFFSET_2200) begin
				yy   = 7'(yoff - CENTURY);
				cent = CENT_21;
			end else begin
				yy   = 7'(yoff - TWO_CENTURY);
				cent = CENT_22;
			end
			// no multiple of 400 falls in the offset range
			leap = (year[1:0] == LEAP_PHASE) && (yy != 7'd0);
			code = 3'd0;
			if (month >= JAN && month <= DEC) begin
				code = month_code(month);
				if (leap && month == JAN) begin
					code = LEAP_JAN_CODE;
				end else if (leap && month == FEB) begin
					code = LEAP_FEB_CODE;
				end
			end
			sum = 8'(cent) + 8'(day) + 8'(code) + 8'(yy) + 8'(yy[6:2]);
			return mod7(sum);
		end
	endfunction

endpackage

/* src/ccw_if.sv */
// ----------------------------------------------------------------------------
// ccw_in_if / ccw_out_if - calendar clock channels
// Valid/ready channels carrying request beats and result beats.
// ----------------------------------------------------------------------------
interface ccw_in_if;
	logic            valid;
	logic            ready;
	ccw_pkg::item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ccw_out_if;
	logic             valid;
	logic             ready;
	ccw_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* src/calendar_clock_with_weekday.sv */
// ----------------------------------------------------------------------------
// calendar_clock_with_weekday - calendar clock with weekday
// Date and time counter advanced by tick beats and loaded by set beats.
// ----------------------------------------------------------------------------
// usage
//   item   : request channel; action low is a one-second tick, action high
//            loads every field whose keep_mask bit is clear, then recomputes
//            the month length and the weekday
//   result : one beat per request, the full calendar after that request
// pipeline
//   an accepted request waits in the request register, then the updated
//   calendar is registered in the result register; one request per cycle is
//   sustained while result.ready stays high
// reset
//   arst_n low clears both pipeline slots; the clock reads year offset 0
//   (2015), 1 january, 00:00:00, thursday, month length 31
// stall
//   while result.ready is low the result beat holds; one further request
//   waits in the request register, after which item.ready drops
// ----------------------------------------------------------------------------
module calendar_clock_with_weekday (
	input  logic          clk,
	input  logic          arst_n,
	ccw_in_if.sink        item,
	ccw_out_if.source     result
);

	// request register
	logic             valid_s1;
	ccw_pkg::item_t   item_s1;

	// calendar state
	logic [7:0] year_q;
	logic [3:0] month_q;
	logic [4:0] day_q;
	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [5:0] second_q;
	logic [2:0] weekday_q;
	logic [4:0] mlen_q;

	// result register
	logic             rsp_valid_q;
	ccw_pkg::result_t rsp_data_q;

	// next calendar
	logic [7:0] year_d;
	logic [3:0] month_d;
	logic [4:0] day_d;
	logic [4:0] hour_d;
	logic [5:0] minute_d;
	logic [5:0] second_d;
	logic [2:0] weekday_d;
	logic [4:0] mlen_d;

	logic out_free;
	logic s1_adv;

	// result slot can take a beat when empty or being drained
	assign out_free    = !rsp_valid_q || result.ready;
	assign s1_adv      = valid_s1 && out_free;
	assign item.ready  = !valid_s1 || out_free;

	assign result.valid = rsp_valid_q;
	assign result.data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	// carry chain for a tick, masked load for a set
	always_comb begin
		year_d    = year_q;
		month_d   = month_q;
		day_d     = day_q;
		hour_d    = hour_q;
		minute_d  = minute_q;
		second_d  = second_q;
		weekday_d = weekday_q;
		mlen_d    = mlen_q;
		if (item_s1.action == ccw_pkg::ACT_TICK) begin
			// out-of-range counts roll on their next step
			if (second_q < ccw_pkg::SECOND_MAX) begin
				second_d = second_q + 6'd1;
			end else begin
				second_d = 6'd0;
				if (minute_q < ccw_pkg::MINUTE_MAX) begin
					minute_d = minute_q + 6'd1;
				end else begin
					minute_d = 6'd0;
					if (hour_q < ccw_pkg::HOUR_MAX) begin
						hour_d = hour_q + 5'd1;
					end else begin
						hour_d    = 5'd0;
						weekday_d = (weekday_q < ccw_pkg::WEEKDAY_MAX) ?
							weekday_q + 3'd1 : 3'd0;
						if (day_q < mlen_q) begin
							day_d = day_q + 5'd1;
						end else begin
							day_d = ccw_pkg::DAY_FIRST;
							if (month_q < ccw_pkg::MONTH_MAX) begin
								month_d = month_q + 4'd1;
							end else begin
								month_d = ccw_pkg::JAN;
								year_d  = year_q + 8'd1;
							end
							mlen_d = ccw_pkg::month_len(month_d, year_d);
						end
					end
				end
			end
		end else begin
			if (!item_s1.keep_mask[ccw_pkg::KEEP_YEAR])   year_d   = item_s1.new_year;
			if (!item_s1.keep_mask[ccw_pkg::KEEP_MONTH])  month_d  = item_s1.new_month;
			if (!item_s1.keep_mask[ccw_pkg::KEEP_DAY])    day_d    = item_s1.new_day;
			if (!item_s1.keep_mask[ccw_pkg::KEEP_HOUR])   hour_d   = item_s1.new_hour;
			if (!item_s1.keep_mask[ccw_pkg::KEEP_MINUTE]) minute_d = item_s1.new_minute;
			if (!item_s1.keep_mask[ccw_pkg::KEEP_SECOND]) second_d = item_s1.new_second;
			mlen_d    = ccw_pkg::month_len(month_d, year_d);
			weekday_d = ccw_pkg::weekday_of(year_d, month_d, day_d);
		end
	end

	// state moves only when the request beat moves into the result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q    <= 8'd0;
			month_q   <= ccw_pkg::JAN;
			day_q     <= ccw_pkg::DAY_FIRST;
			hour_q    <= 5'd0;
			minute_q  <= 6'd0;
			second_q  <= 6'd0;
			weekday_q <= ccw_pkg::WEEKDAY_RESET;
			mlen_q    <= ccw_pkg::LEN_31;
		end else if (s1_adv) begin
			year_q    <= year_d;
			month_q   <= month_d;
			day_q     <= day_d;
			hour_q    <= hour_d;
			minute_q  <= minute_d;
			second_q  <= second_d;
			weekday_q <= weekday_d;
			mlen_q    <= mlen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (result.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_data_q.year_out    <= year_d;
			rsp_data_q.month_out   <= month_d;
			rsp_data_q.day_out     <= day_d;
			rsp_data_q.hour_out    <= hour_d;
			rsp_data_q.minute_out  <= minute_d;
			rsp_data_q.second_out  <= second_d;
			rsp_data_q.weekday_out <= weekday_d;
		end
	end

endmodule

/* src/ccw_checker.sv */
// ----------------------------------------------------------------------------
// ccw_checker - calendar clock port checks
// Watches the channels of the calendar clock and flags misbehaviour.
// ----------------------------------------------------------------------------
module ccw_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input ccw_pkg::result_t out_data
);

	// a stalled result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result payload changed while stalled");

	// a fresh result beat comes from an accepted request that has passed the request register
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result beat without a request");

	// weekday always in sunday..saturday
	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.weekday_out <= ccw_pkg::WEEKDAY_MAX)
		else $error("weekday out of range");

endmodule

bind calendar_clock_with_weekday ccw_checker u_ccw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - calendar clock with weekday testbench
// Drives tick and set beats through the request channel and compares every
// result beat with a calendar kept alongside. Directed roll-over and
// out-of-range cases come first, then random sets near roll-over points
// followed by tick bursts, under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_PER_PHASE = 363;
	localparam int unsigned BASE_YEAR = 2015;

	// keep masks built from the field positions
	localparam logic [5:0] KEEP_NONE = 6'b0;
	localparam logic [5:0] KEEP_ALL  = 6'b111111;
	localparam logic [5:0] KEEP_DATE = (6'b1 << ccw_pkg::KEEP_YEAR)
		| (6'b1 << ccw_pkg::KEEP_MONTH) | (6'b1 << ccw_pkg::KEEP_DAY);
	localparam logic [5:0] KEEP_ODD  = (6'b1 << ccw_pkg::KEEP_MONTH)
		| (6'b1 << ccw_pkg::KEEP_HOUR) | (6'b1 << ccw_pkg::KEEP_SECOND);

	// ------------------------------------------------------------------------
	// calendar tracker: own copy of the clock, queue of calendars still owed
	// ------------------------------------------------------------------------
	class calendar_tracker;
		int unsigned      yr_cnt, mon_cnt, day_cnt, hr_cnt, min_cnt, sec_cnt;
		int unsigned      wday_cnt, mon_len;
		ccw_pkg::result_t owed_calendars[$];
		int unsigned      mismatches, checked, sets, ticks;
		int unsigned      midnights, month_rolls, year_wraps;

		function new();
			yr_cnt   = 0;
			mon_cnt  = 1;
			day_cnt  = 1;
			hr_cnt   = 0;
			min_cnt  = 0;
			sec_cnt  = 0;
			wday_cnt = 4;
			mon_len  = 31;
		endfunction

		// february by the plain divide-by-four rule on the calendar year
		static function int unsigned month_days(int unsigned mon, int unsigned yr);
			case (mon)
				ccw_pkg::FEB: return ((yr + BASE_YEAR) % 4 == 0) ? 29 : 28;
				ccw_pkg::APR, ccw_pkg::JUN, ccw_pkg::SEP, ccw_pkg::NOV: return 30;
				default:      return 31;
			endcase
		endfunction

		// table formula, gregorian leap test, january entry for a bad month
		static function int unsigned day_of_week(int unsigned yr, int unsigned mon,
			int unsigned dom);
			int unsigned full_yr, cent, yy, code, total;
			bit          leap;
			full_yr = yr + BASE_YEAR;
			cent    = full_yr / 100;
			yy      = full_yr % 100;
			leap    = (full_yr % 4 == 0) && ((full_yr % 100 != 0) || (full_yr % 400 == 0));
			code    = 0;
			if (mon >= 1 && mon <= 12) begin
				case (mon)
					2, 3, 11: code = 3;
					4, 7:     code = 6;
					5:        code = 1;
					6:        code = 4;
					8:        code = 2;
					9, 12:    code = 5;
					default:  code = 0;
				endcase
				if (leap && mon == ccw_pkg::JAN) begin
					code = 6;
				end else if (leap && mon == ccw_pkg::FEB) begin
					code = 2;
				end
			end
			total = (6 - 2 * (cent % 4)) + dom + code + yy + yy / 4;
			return total % 7;
		endfunction

		// one second forward; each count rolls once at or past its limit
		function void advance_second();
			if (sec_cnt < ccw_pkg::SECOND_MAX) begin
				sec_cnt++;
				return;
			end
			sec_cnt = 0;
			if (min_cnt < ccw_pkg::MINUTE_MAX) begin
				min_cnt++;
				return;
			end
			min_cnt = 0;
			if (hr_cnt < ccw_pkg::HOUR_MAX) begin
				hr_cnt++;
				return;
			end
			hr_cnt = 0;
			midnights++;
			wday_cnt = (wday_cnt < ccw_pkg::WEEKDAY_MAX) ? wday_cnt + 1 : 0;
			if (day_cnt < mon_len) begin
				day_cnt++;
				return;
			end
			day_cnt = 1;
			month_rolls++;
			if (mon_cnt < ccw_pkg::MONTH_MAX) begin
				mon_cnt++;
			end else begin
				mon_cnt = 1;
				if (yr_cnt == 255) year_wraps++;
				yr_cnt = (yr_cnt + 1) & 8'hFF;
			end
			mon_len = month_days(mon_cnt, yr_cnt);
		endfunction

		function void note_request(ccw_pkg::item_t req);
			ccw_pkg::result_t owed;
			if (req.action == ccw_pkg::ACT_TICK) begin
				ticks++;
				advance_second();
			end else begin
				sets++;
				if (!req.keep_mask[ccw_pkg::KEEP_YEAR])   yr_cnt  = req.new_year;
				if (!req.keep_mask[ccw_pkg::KEEP_MONTH])  mon_cnt = req.new_month;
				if (!req.keep_mask[ccw_pkg::KEEP_DAY])    day_cnt = req.new_day;
				if (!req.keep_mask[ccw_pkg::KEEP_HOUR])   hr_cnt  = req.new_hour;
				if (!req.keep_mask[ccw_pkg::KEEP_MINUTE]) min_cnt = req.new_minute;
				if (!req.keep_mask[ccw_pkg::KEEP_SECOND]) sec_cnt = req.new_second;
				mon_len  = month_days(mon_cnt, yr_cnt);
				wday_cnt = day_of_week(yr_cnt, mon_cnt, day_cnt);
			end
			owed.year_out    = 8'(yr_cnt);
			owed.month_out   = 4'(mon_cnt);
			owed.day_out     = 5'(day_cnt);
			owed.hour_out    = 5'(hr_cnt);
			owed.minute_out  = 6'(min_cnt);
			owed.second_out  = 6'(sec_cnt);
			owed.weekday_out = 3'(wday_cnt);
			owed_calendars.push_back(owed);
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_calendar(ccw_pkg::result_t got);
			ccw_pkg::result_t want;
			if (owed_calendars.size() == 0) begin
				$error("calendar beat arrived with nothing owed");
				mismatches++;
				return;
			end
			want = owed_calendars.pop_front();
			checked++;
			check_field("year_out", want.year_out, got.year_out);
			check_field("month_out", want.month_out, got.month_out);
			check_field("day_out", want.day_out, got.day_out);
			check_field("hour_out", want.hour_out, got.hour_out);
			check_field("minute_out", want.minute_out, got.minute_out);
			check_field("second_out", want.second_out, got.second_out);
			check_field("weekday_out", want.weekday_out, got.weekday_out);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset, channels and the block
	// ------------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned cycle_count = 0;
	int unsigned gap_pct = 0;     // sender idle chance per cycle, percent
	int unsigned stall_pct = 0;   // receiver stall chance per cycle, percent

	calendar_tracker tracker = new();

	ccw_in_if  item_ch ();
	ccw_out_if result_ch ();

	calendar_clock_with_weekday u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------------
	// result side: check each accepted beat, then pick ready for the next edge
	// values are read right after the edge, so they are the pre-edge ones
	// ------------------------------------------------------------------------
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				tracker.check_calendar(result_ch.data);
			end
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------

	// random idle cycles first, then hold valid until the beat is taken;
	// valid stays high into the next beat when no gap is drawn
	task automatic send_beat(input ccw_pkg::item_t beat);
		while ($urandom_range(99) < gap_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= beat;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		tracker.note_request(beat);
	endtask

	// tick beat; the set fields carry noise since the block ignores them
	task automatic send_tick();
		ccw_pkg::item_t beat;
		beat        = ccw_pkg::item_t'({$urandom, $urandom});
		beat.action = ccw_pkg::ACT_TICK;
		send_beat(beat);
	endtask

	task automatic send_set(input logic [5:0] keep, input int unsigned yr, mon, dom, hr, mi, sec);
		ccw_pkg::item_t beat;
		beat.action     = ccw_pkg::ACT_SET;
		beat.keep_mask  = keep;
		beat.new_year   = 8'(yr);
		beat.new_month  = 4'(mon);
		beat.new_day    = 5'(dom);
		beat.new_hour   = 5'(hr);
		beat.new_minute = 6'(mi);
		beat.new_second = 6'(sec);
		send_beat(beat);
	endtask

	// mostly well-formed sets parked just before a roll-over and followed by
	// tick bursts, with some full-width noise sets and plain tick runs
	task automatic run_random(input int unsigned beats);
		int unsigned    start, pick, yr, mon, dom, hr, mi, sec, burst;
		logic [5:0]     keep;
		ccw_pkg::item_t noise;
		start = tracker.sets + tracker.ticks;
		while (tracker.sets + tracker.ticks - start < beats) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				case ($urandom_range(7))
					0:       yr = 255;
					1:       yr = 84 + $urandom_range(1);   // 2099 and 2100
					2:       yr = 184 + $urandom_range(1);  // 2199 and 2200
					default: yr = $urandom_range(255);
				endcase
				mon  = ($urandom_range(3) == 0) ? 12 : $urandom_range(1, 12);
				dom  = ($urandom_range(1) == 0) ? calendar_tracker::month_days(mon, yr)
					: $urandom_range(1, calendar_tracker::month_days(mon, yr));
				hr   = ($urandom_range(3) != 0) ? 23 : $urandom_range(23);
				mi   = ($urandom_range(3) != 0) ? 59 : $urandom_range(59);
				sec  = ($urandom_range(3) != 0) ? $urandom_range(50, 59) : $urandom_range(59);
				keep = ($urandom_range(4) == 0) ? 6'($urandom) : KEEP_NONE;
				send_set(keep, yr, mon, dom, hr, mi, sec);
				burst = $urandom_range(1, 12);
				repeat (burst) send_tick();
			end else if (pick < 88) begin
				noise        = ccw_pkg::item_t'({$urandom, $urandom});
				noise.action = ccw_pkg::ACT_SET;
				send_beat(noise);
				burst = $urandom_range(3);
				repeat (burst) send_tick();
			end else begin
				burst = $urandom_range(1, 20);
				repeat (burst) send_tick();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n        <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: carries, leap days, century years, bad values, keep masks
		send_tick();                                   // first tick from reset
		send_set(KEEP_NONE, 255, 12, 31, 23, 59, 59);  // last second of offset 255
		send_tick();                                   // year wraps to 2015
		send_set(KEEP_NONE, 1, 2, 28, 23, 59, 59);     // 2016, leap february
		send_tick();                                   // into the 29th
		send_set(KEEP_DATE, 0, 0, 0, 23, 59, 59);      // time only, date kept
		send_tick();                                   // 29th rolls to march
		send_set(KEEP_NONE, 2, 2, 28, 23, 59, 59);     // 2017, short february
		send_tick();
		send_set(KEEP_NONE, 0, 1, 3, 23, 59, 59);      // a saturday
		send_tick();                                   // weekday wraps to sunday
		send_set(KEEP_NONE, 0, 4, 30, 23, 59, 59);     // thirty-day month
		send_tick();
		send_set(KEEP_NONE, 85, 2, 28, 23, 59, 59);    // 2100, not gregorian leap
		send_tick();
		send_set(KEEP_NONE, 185, 1, 1, 0, 0, 0);       // 2200
		send_set(KEEP_NONE, 84, 12, 31, 12, 30, 30);   // 2099
		send_set(KEEP_NONE, 255, 15, 31, 31, 63, 63);  // month, hour, minute and second out of range
		send_tick();                                   // each bad count clears
		send_set(KEEP_NONE, 0, 0, 0, 0, 0, 0);         // month and day zero
		send_tick();
		send_set(KEEP_ALL, 200, 9, 17, 5, 33, 44);     // nothing loaded
		send_set(KEEP_ODD, 200, 9, 17, 5, 33, 44);
		send_tick();

		// random phases: free running, sender gaps, receiver stalls, both
		gap_pct   = 0;
		stall_pct = 0;
		run_random(RANDOM_PER_PHASE);
		gap_pct   = 66;
		stall_pct = 0;
		run_random(RANDOM_PER_PHASE);
		gap_pct   = 0;
		stall_pct = 66;
		run_random(RANDOM_PER_PHASE);
		gap_pct   = 29;
		stall_pct = 29;
		run_random(RANDOM_PER_PHASE);
		item_ch.valid <= 1'b0;

		// drain, then keep running to catch stray beats
		while (tracker.owed_calendars.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d request beats (%0d set, %0d tick), %0d calendars checked",
			tracker.sets + tracker.ticks, tracker.sets, tracker.ticks, tracker.checked);
		$display("%0d midnight carries, %0d month roll-overs, %0d year wraps",
			tracker.midnights, tracker.month_rolls, tracker.year_wraps);
		if (tracker.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* files.f */
src/ccw_pkg.sv
src/ccw_if.sv
src/calendar_clock_with_weekday.sv
src/ccw_checker.sv
tb/tb.sv
